[src/rbfa_pkg.sv]
// rbfa_pkg: shared types and constants for the random bitmap frame allocator
// no dependencies; used by every module of the allocator
`default_nettype none

package rbfa_pkg;

    localparam int RND_W   = 31;
    localparam int RND_CW  = $clog2(RND_W);
    localparam int FREE_W  = 7;
    localparam int FB_W    = 17;
    localparam int PS_W    = 32;
    localparam int IDX_W   = 6;
    localparam int CHUNK_W = 8;

    localparam logic [FREE_W-1:0] FRAMES_RESET = 7'd64;
    localparam logic [FB_W-1:0]   FBYTES_RESET = 17'd4096;

    localparam logic REG_FRAMES = 1'b0;
    localparam logic REG_FBYTES = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_CHECK = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFREE = 2'd1,
        STAT_RANGE  = 2'd2
    } stat_t;

    typedef struct packed {
        logic load;
        logic count_step;
        logic div_start;
        logic nofree;
        logic search_step;
        logic free_apply;
        logic mul_step;
        logic result;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t op;
        logic count_last;
        logic count_zero;
        logic search_hit;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

[src/rbfa_mod.sv]
// rbfa_mod: iterative remainder unit, one dividend bit per cycle
// depends on rbfa_pkg
`default_nettype none

module rbfa_mod
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [rbfa_pkg::RND_W-1:0]      dividend,
    input  wire logic [rbfa_pkg::FREE_W-1:0]     divisor,
    output logic                                 done,
    output logic [rbfa_pkg::FREE_W-1:0]          rem
);

    logic                             run_reg;
    logic [rbfa_pkg::RND_CW-1:0]      cnt_reg;
    logic                             done_reg;
    logic [rbfa_pkg::RND_W-1:0]       dvd_reg;
    logic [rbfa_pkg::FREE_W-1:0]      rem_reg;
    logic [rbfa_pkg::FREE_W:0]        trial;
    logic [rbfa_pkg::FREE_W:0]        diff;
    logic [rbfa_pkg::FREE_W-1:0]      rem_next;
    logic                             last;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[rbfa_pkg::RND_W-1]};
        diff     = trial - {1'b0, divisor};
        rem_next = (trial >= {1'b0, divisor}) ? diff[rbfa_pkg::FREE_W-1:0]
                                              : trial[rbfa_pkg::FREE_W-1:0];
        last     = (cnt_reg == rbfa_pkg::RND_CW'(rbfa_pkg::RND_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && last;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[rbfa_pkg::RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

[src/rbfa_dp.sv]
// rbfa_dp: datapath with busy map, config registers, count/search scan and fit check
// depends on rbfa_pkg and rbfa_mod
`default_nettype none

module rbfa_dp
#(
    parameter int MAX_FRAMES = 64
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [1:0]                      command,
    input  wire logic [rbfa_pkg::IDX_W-1:0]      frame_index,
    input  wire logic [rbfa_pkg::RND_W-1:0]      random_value,
    input  wire logic [rbfa_pkg::PS_W-1:0]       proc_size,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [rbfa_pkg::FB_W-1:0]       cfg_data,
    input  wire rbfa_pkg::dp_cmd_t               ctl,
    output rbfa_pkg::dp_stat_t                   stat,
    output logic [1:0]                           status,
    output logic [rbfa_pkg::IDX_W-1:0]           granted_frame,
    output logic [rbfa_pkg::FREE_W-1:0]          free_total,
    output logic                                 fits
);

    localparam int NCH  = (MAX_FRAMES + rbfa_pkg::CHUNK_W - 1) / rbfa_pkg::CHUNK_W;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IW   = $clog2(MAX_FRAMES);
    localparam int XW   = (CW + 3 > rbfa_pkg::FREE_W) ? CW + 3 : rbfa_pkg::FREE_W;
    localparam int CAP  = (MAX_FRAMES < 127) ? MAX_FRAMES : 127;
    localparam int PADW = NCH * rbfa_pkg::CHUNK_W;
    localparam logic [rbfa_pkg::FREE_W-1:0] CAP7 = rbfa_pkg::FREE_W'(CAP);

    logic [rbfa_pkg::FREE_W-1:0]      frames_reg;
    logic [rbfa_pkg::FB_W-1:0]        fbytes_reg;
    logic [MAX_FRAMES-1:0]            busy_map_reg;
    logic [CW-1:0]                    chunk_reg;
    logic [rbfa_pkg::FREE_W-1:0]      acc_reg;

    rbfa_pkg::cmd_t                   op_reg;
    logic [rbfa_pkg::IDX_W-1:0]       idx_reg;
    logic [rbfa_pkg::RND_W-1:0]       rnd_reg;
    logic [rbfa_pkg::PS_W-1:0]        psize_reg;
    rbfa_pkg::stat_t                  status_reg;
    logic [XW-1:0]                    granted_reg;
    logic [rbfa_pkg::FREE_W-1:0]      free_reg;
    logic                             fits_reg;

    logic [rbfa_pkg::FREE_W-1:0]      n_frames;
    logic [PADW-1:0]                  busy_pad;
    logic [rbfa_pkg::CHUNK_W-1:0]     chunk_busy;
    logic [rbfa_pkg::CHUNK_W-1:0]     free_bits;
    logic [3:0]                       pc;
    logic [rbfa_pkg::FREE_W:0]        acc_sum;
    logic [rbfa_pkg::FREE_W:0]        rank;
    logic [2:0]                       sel;
    logic                             found;
    logic [XW-1:0]                    sel_index;
    logic [XW-1:0]                    idx_ext;
    logic                             in_range;
    logic [rbfa_pkg::FREE_W+rbfa_pkg::FB_W-1:0] prod;
    logic                             div_done;
    logic [rbfa_pkg::FREE_W-1:0]      target;

    always_comb
    begin
        n_frames = (frames_reg > CAP7) ? CAP7 : frames_reg;
        busy_pad = '1;
        busy_pad[MAX_FRAMES-1:0] = busy_map_reg;
        chunk_busy = busy_pad[{chunk_reg, 3'b000} +: rbfa_pkg::CHUNK_W];
        for (int j = 0; j < rbfa_pkg::CHUNK_W; j++)
        begin
            free_bits[j] = !chunk_busy[j]
                && (XW'({chunk_reg, 3'(j)}) < XW'(n_frames));
        end
        pc = '0;
        for (int j = 0; j < rbfa_pkg::CHUNK_W; j++)
        begin
            pc = pc + 4'(free_bits[j]);
        end
        acc_sum = {1'b0, acc_reg} + (rbfa_pkg::FREE_W+1)'(pc);
        rank  = {1'b0, acc_reg};
        sel   = '0;
        found = 1'b0;
        for (int j = 0; j < rbfa_pkg::CHUNK_W; j++)
        begin
            if (free_bits[j] && !found && (rank == {1'b0, target}))
            begin
                sel   = 3'(j);
                found = 1'b1;
            end
            if (free_bits[j])
            begin
                rank = rank + 1'b1;
            end
        end
        sel_index = XW'({chunk_reg, sel});
        idx_ext   = XW'(idx_reg);
        in_range  = idx_ext < XW'(n_frames);
        prod      = free_reg * fbytes_reg;
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.count_last = (chunk_reg == CW'(NCH - 1));
        stat.count_zero = (acc_sum == '0);
        stat.search_hit = ({1'b0, target} < acc_sum);
        stat.div_done   = div_done;
    end

    rbfa_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (rnd_reg),
        .divisor  (free_reg),
        .done     (div_done),
        .rem      (target)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= rbfa_pkg::FRAMES_RESET;
            fbytes_reg <= rbfa_pkg::FBYTES_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rbfa_pkg::REG_FRAMES)
            begin
                frames_reg <= cfg_data[rbfa_pkg::FREE_W-1:0];
            end
            else
            begin
                fbytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_map_reg <= '0;
            chunk_reg    <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            if (ctl.load || ctl.div_start)
            begin
                chunk_reg <= '0;
                acc_reg   <= '0;
            end
            else if (ctl.count_step || (ctl.search_step && !stat.search_hit))
            begin
                chunk_reg <= chunk_reg + 1'b1;
                acc_reg   <= acc_sum[rbfa_pkg::FREE_W-1:0];
            end
            if (ctl.search_step && stat.search_hit)
            begin
                busy_map_reg[sel_index[IW-1:0]] <= 1'b1;
            end
            if (ctl.free_apply && in_range)
            begin
                busy_map_reg[idx_ext[IW-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg      <= rbfa_pkg::cmd_t'(command);
            idx_reg     <= frame_index;
            rnd_reg     <= random_value;
            psize_reg   <= proc_size;
            status_reg  <= rbfa_pkg::STAT_OK;
            granted_reg <= '0;
            fits_reg    <= 1'b0;
        end
        if (ctl.count_step && stat.count_last)
        begin
            free_reg <= acc_sum[rbfa_pkg::FREE_W-1:0];
        end
        if (ctl.nofree)
        begin
            status_reg <= rbfa_pkg::STAT_NOFREE;
        end
        if (ctl.search_step && stat.search_hit)
        begin
            granted_reg <= sel_index;
            free_reg    <= free_reg - 1'b1;
        end
        if (ctl.free_apply)
        begin
            if (!in_range)
            begin
                status_reg <= rbfa_pkg::STAT_RANGE;
            end
            else if (busy_map_reg[idx_ext[IW-1:0]])
            begin
                free_reg <= free_reg + 1'b1;
            end
        end
        if (ctl.mul_step)
        begin
            fits_reg <= (rbfa_pkg::PS_W'(prod) >= psize_reg);
        end
    end

    assign status        = status_reg;
    assign granted_frame = granted_reg[rbfa_pkg::IDX_W-1:0];
    assign free_total    = free_reg;
    assign fits          = fits_reg;

    a_granted_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.result && (op_reg == rbfa_pkg::CMD_ALLOC) && (status_reg == rbfa_pkg::STAT_OK))
        |-> busy_map_reg[granted_reg[IW-1:0]])
        else $error("granted frame not marked busy");

    a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result |-> (free_reg <= n_frames))
        else $error("free total above frame count");

endmodule

`default_nettype wire

[src/rbfa_ctrl.sv]
// rbfa_ctrl: command sequencer for the allocator datapath
// depends on rbfa_pkg
`default_nettype none

module rbfa_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire rbfa_pkg::dp_stat_t   stat,
    output rbfa_pkg::dp_cmd_t         ctl,
    output logic                      busy,
    output logic                      done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_COUNT  = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_SEARCH = 7'b0001000,
        S_FREE   = 7'b0010000,
        S_MUL    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   count_end;
    logic   is_alloc;

    always_comb
    begin
        count_end  = (state_reg == S_COUNT) && stat.count_last;
        is_alloc   = (stat.op == rbfa_pkg::CMD_ALLOC);
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (stat.count_last)
                begin
                    unique case (stat.op)
                        rbfa_pkg::CMD_ALLOC: state_next = stat.count_zero ? S_DONE : S_DIV;
                        rbfa_pkg::CMD_FREE:  state_next = S_FREE;
                        rbfa_pkg::CMD_COUNT: state_next = S_DONE;
                        rbfa_pkg::CMD_CHECK: state_next = S_MUL;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.search_hit)
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE:  state_next = S_DONE;
            S_MUL:   state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl.load        = (state_reg == S_IDLE) && start;
        ctl.count_step  = (state_reg == S_COUNT);
        ctl.div_start   = count_end && is_alloc && !stat.count_zero;
        ctl.nofree      = count_end && is_alloc && stat.count_zero;
        ctl.search_step = (state_reg == S_SEARCH);
        ctl.free_apply  = (state_reg == S_FREE);
        ctl.mul_step    = (state_reg == S_MUL);
        ctl.result      = (state_reg == S_DONE);
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command did not start");

    a_search_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SEARCH) && !$past(state_reg == S_SEARCH)) |-> $past(stat.div_done))
        else $error("search entered without remainder");

endmodule

`default_nettype wire

[src/random_bitmap_frame_allocator_core.sv]
// random_bitmap_frame_allocator_core: top level of the random bitmap frame allocator
// depends on rbfa_pkg, rbfa_ctrl and rbfa_dp
//
// One command at a time: a command is taken when start is high and busy is low, and its
// single result appears on status, granted_frame, free_total and fits for exactly one
// cycle with done high; the receiver cannot stall it. Every command first scans the busy
// map eight frames per cycle. Count, and allocate with no free frame, then go straight to
// the result; free passes through a free step and check through a multiply step, which
// multiplies the free total by the frame size once. Allocate with a free frame adds a
// remainder unit that takes one bit of random_value per cycle, then a rank search over
// the chunks that stops at the chunk holding the chosen frame, and then the result.
// Configuration writes are always ready and are to be made while busy is low.
// The busy map is cleared by reset directly.
`default_nettype none

module random_bitmap_frame_allocator_core
#(
    parameter int MAX_FRAMES = 64
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      command,
    input  wire logic [rbfa_pkg::IDX_W-1:0]      frame_index,
    input  wire logic [rbfa_pkg::RND_W-1:0]      random_value,
    input  wire logic [rbfa_pkg::PS_W-1:0]       proc_size,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [rbfa_pkg::IDX_W-1:0]           granted_frame,
    output logic [rbfa_pkg::FREE_W-1:0]          free_total,
    output logic                                 fits,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [rbfa_pkg::FB_W-1:0]       cfg_data
);

    rbfa_pkg::dp_cmd_t  ctl;
    rbfa_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rbfa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    rbfa_dp
    #(
        .MAX_FRAMES (MAX_FRAMES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .frame_index   (frame_index),
        .random_value  (random_value),
        .proc_size     (proc_size),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ctl           (ctl),
        .stat          (stat),
        .status        (status),
        .granted_frame (granted_frame),
        .free_total    (free_total),
        .fits          (fits)
    );

endmodule

`default_nettype wire

[test/random_bitmap_frame_allocator_core_test.sv]
`timescale 1ns / 1ps
// random_bitmap_frame_allocator_core_test: self-checking bench for the bitmap frame allocator
// depends on rbfa_pkg and random_bitmap_frame_allocator_core; predicts every reply from
// its own copy of the busy map and compares each done strobe field by field

module random_bitmap_frame_allocator_core_test;

    localparam int FRAME_LIMIT = 64;

    typedef struct {
        logic [1:0]                  status;
        logic [rbfa_pkg::IDX_W-1:0]  frame;
        logic [rbfa_pkg::FREE_W-1:0] free_total;
        logic                        fits;
    } reply_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    rbfa_pkg::cmd_t              command;
    logic [rbfa_pkg::IDX_W-1:0]  frame_index;
    logic [rbfa_pkg::RND_W-1:0]  random_value;
    logic [rbfa_pkg::PS_W-1:0]   proc_size;
    logic                        done;
    logic [1:0]                  status;
    logic [rbfa_pkg::IDX_W-1:0]  granted_frame;
    logic [rbfa_pkg::FREE_W-1:0] free_total;
    logic                        fits;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic                        cfg_index;
    logic [rbfa_pkg::FB_W-1:0]   cfg_data;

    logic [FRAME_LIMIT-1:0]      frame_busy;
    logic [rbfa_pkg::FREE_W-1:0] frames_reg;
    logic [rbfa_pkg::FB_W-1:0]   bytes_reg;
    reply_t                      pending_replies[$];
    int                          error_count = 0;
    bit                          steady = 0;

    random_bitmap_frame_allocator_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .frame_index   (frame_index),
        .random_value  (random_value),
        .proc_size     (proc_size),
        .done          (done),
        .status        (status),
        .granted_frame (granted_frame),
        .free_total    (free_total),
        .fits          (fits),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int active_frames();
        return (frames_reg < FRAME_LIMIT) ? int'(frames_reg) : FRAME_LIMIT;
    endfunction

    function automatic int free_count();
        int n;
        int c;
        int i;
        n = active_frames();
        c = 0;
        for (i = 0; i < n; i++)
            if (!frame_busy[i])
                c++;
        return c;
    endfunction

    function automatic reply_t predict_reply(rbfa_pkg::cmd_t op,
                                             logic [rbfa_pkg::IDX_W-1:0] idx,
                                             logic [rbfa_pkg::RND_W-1:0] rnd,
                                             logic [rbfa_pkg::PS_W-1:0] psize);
        reply_t            r;
        int                n;
        int                avail;
        int                target;
        int                rank;
        int                i;
        bit                placed;
        longint unsigned   need;
        r.status = rbfa_pkg::STAT_OK;
        r.frame  = '0;
        r.fits   = 1'b0;
        n = active_frames();
        unique case (op)
            rbfa_pkg::CMD_ALLOC:
            begin
                avail = free_count();
                if (avail == 0)
                    r.status = rbfa_pkg::STAT_NOFREE;
                else
                begin
                    target = int'(longint'(rnd) % avail);
                    rank   = 0;
                    placed = 0;
                    for (i = 0; i < n && !placed; i++)
                    begin
                        if (!frame_busy[i])
                        begin
                            if (rank == target)
                            begin
                                frame_busy[i] = 1'b1;
                                r.frame = rbfa_pkg::IDX_W'(i);
                                placed = 1;
                            end
                            rank++;
                        end
                    end
                end
            end
            rbfa_pkg::CMD_FREE:
            begin
                if (int'(idx) < n)
                    frame_busy[idx] = 1'b0;
                else
                    r.status = rbfa_pkg::STAT_RANGE;
            end
            rbfa_pkg::CMD_CHECK:
            begin
                avail = free_count();
                if (bytes_reg == '0)
                    r.fits = (psize == '0);
                else
                begin
                    need = ({32'd0, psize} + 64'(bytes_reg) - 64'd1) / 64'(bytes_reg);
                    r.fits = (64'(avail) >= need);
                end
            end
            default:
            begin
            end
        endcase
        r.free_total = rbfa_pkg::FREE_W'(free_count());
        return r;
    endfunction

    task automatic check_reply();
        reply_t exp;
        if (pending_replies.size() == 0)
        begin
            $error("unexpected reply: status %0d granted_frame %0d free_total %0d fits %0d",
                   status, granted_frame, free_total, fits);
            error_count++;
        end
        else
        begin
            exp = pending_replies.pop_front();
            if (status !== exp.status)
            begin
                $error("status expected %0d actual %0d", exp.status, status);
                error_count++;
            end
            if (granted_frame !== exp.frame)
            begin
                $error("granted_frame expected %0d actual %0d", exp.frame, granted_frame);
                error_count++;
            end
            if (free_total !== exp.free_total)
            begin
                $error("free_total expected %0d actual %0d", exp.free_total, free_total);
                error_count++;
            end
            if (fits !== exp.fits)
            begin
                $error("fits expected %0d actual %0d", exp.fits, fits);
                error_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            check_reply();
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_command(rbfa_pkg::cmd_t op, logic [rbfa_pkg::IDX_W-1:0] idx,
                                logic [rbfa_pkg::RND_W-1:0] rnd,
                                logic [rbfa_pkg::PS_W-1:0] psize);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start        <= 1'b0;
            command      <= rbfa_pkg::cmd_t'($urandom_range(0, 3));
            frame_index  <= rbfa_pkg::IDX_W'($urandom);
            random_value <= rbfa_pkg::RND_W'($urandom);
            proc_size    <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        command      <= op;
        frame_index  <= idx;
        random_value <= rnd;
        proc_size    <= psize;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_replies.push_back(predict_reply(op, idx, rnd, psize));
    endtask

    task automatic write_reg(logic idx, logic [rbfa_pkg::FB_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == rbfa_pkg::REG_FRAMES)
            frames_reg = value[rbfa_pkg::FREE_W-1:0];
        else
            bytes_reg = value;
    endtask

    task automatic test_reset_state();
        send_command(rbfa_pkg::CMD_COUNT, '0, '0, '0);
        send_command(rbfa_pkg::CMD_CHECK, '0, '0, 32'd0);
        send_command(rbfa_pkg::CMD_CHECK, '0, '0, 32'd262144);
        send_command(rbfa_pkg::CMD_CHECK, '0, '0, 32'd262145);
        send_command(rbfa_pkg::CMD_CHECK, 6'h3f, 31'h7fffffff, 32'hffffffff);
    endtask

    task automatic test_alloc_and_free();
        send_command(rbfa_pkg::CMD_ALLOC, '0, 31'd0, '0);
        send_command(rbfa_pkg::CMD_ALLOC, '0, 31'h7fffffff, '0);
        send_command(rbfa_pkg::CMD_FREE, 6'd0, '0, '0);
        send_command(rbfa_pkg::CMD_FREE, 6'd0, '0, '0);
        send_command(rbfa_pkg::CMD_FREE, 6'd63, '0, '0);
    endtask

    task automatic test_no_frames();
        write_reg(rbfa_pkg::REG_FRAMES, 17'd0);
        send_command(rbfa_pkg::CMD_ALLOC, '0, 31'd5, '0);
        send_command(rbfa_pkg::CMD_FREE, 6'd0, '0, '0);
        send_command(rbfa_pkg::CMD_COUNT, '0, '0, '0);
        send_command(rbfa_pkg::CMD_CHECK, '0, '0, 32'd0);
        send_command(rbfa_pkg::CMD_CHECK, '0, '0, 32'd1);
    endtask

    task automatic test_zero_frame_size();
        write_reg(rbfa_pkg::REG_FBYTES, 17'd0);
        send_command(rbfa_pkg::CMD_CHECK, '0, '0, 32'd0);
        send_command(rbfa_pkg::CMD_CHECK, '0, '0, 32'd1);
    endtask

    task automatic test_shrink_and_grow();
        int k;
        write_reg(rbfa_pkg::REG_FRAMES, 17'd4);
        for (k = 0; k < 5; k++)
            send_command(rbfa_pkg::CMD_ALLOC, '0, rbfa_pkg::RND_W'($urandom), '0);
        send_command(rbfa_pkg::CMD_FREE, 6'd4, '0, '0);
        write_reg(rbfa_pkg::REG_FRAMES, 17'd127);
        send_command(rbfa_pkg::CMD_COUNT, '0, '0, '0);
    endtask

    task automatic test_random_traffic(logic [rbfa_pkg::FREE_W-1:0] frames,
                                       logic [rbfa_pkg::FB_W-1:0] fbytes, int items);
        int                         k;
        int                         j;
        int                         n;
        int                         base;
        int                         roll;
        bit                         found;
        rbfa_pkg::cmd_t             op;
        logic [rbfa_pkg::IDX_W-1:0] idx;
        logic [rbfa_pkg::PS_W-1:0]  psize;
        write_reg(rbfa_pkg::REG_FRAMES,
                  {{(rbfa_pkg::FB_W-rbfa_pkg::FREE_W){1'b0}}, frames});
        write_reg(rbfa_pkg::REG_FBYTES, fbytes);
        for (k = 0; k < items; k++)
        begin
            if (k % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            roll  = $urandom_range(0, 99);
            idx   = rbfa_pkg::IDX_W'($urandom);
            psize = $urandom;
            n     = active_frames();
            if (roll < 45)
                op = rbfa_pkg::CMD_ALLOC;
            else if (roll < 75)
            begin
                op = rbfa_pkg::CMD_FREE;
                if (n > 0 && $urandom_range(0, 3) != 0)
                begin
                    base  = $urandom_range(0, n - 1);
                    found = 0;
                    for (j = 0; j < n && !found; j++)
                    begin
                        if (frame_busy[(base + j) % n])
                        begin
                            idx   = rbfa_pkg::IDX_W'((base + j) % n);
                            found = 1;
                        end
                    end
                end
            end
            else if (roll < 85)
                op = rbfa_pkg::CMD_COUNT;
            else
            begin
                op = rbfa_pkg::CMD_CHECK;
                if ($urandom_range(0, 2) != 0)
                    psize = $urandom_range(0, 32'(bytes_reg) * 32'(free_count() + 2));
            end
            send_command(op, idx, rbfa_pkg::RND_W'($urandom), psize);
        end
    endtask

    initial
    begin
        int drain;
        start        <= 1'b0;
        command      <= rbfa_pkg::CMD_COUNT;
        frame_index  <= '0;
        random_value <= '0;
        proc_size    <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= rbfa_pkg::REG_FRAMES;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        frame_busy = '0;
        frames_reg = rbfa_pkg::FRAMES_RESET;
        bytes_reg  = rbfa_pkg::FBYTES_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_alloc_and_free();
        test_no_frames();
        test_zero_frame_size();
        test_shrink_and_grow();

        test_random_traffic(7'd64, 17'd4096, 220);
        test_random_traffic(7'd1, 17'd1, 120);
        test_random_traffic(7'd127, 17'd131071, 220);
        test_random_traffic(rbfa_pkg::FREE_W'($urandom_range(2, 63)),
                            rbfa_pkg::FB_W'($urandom_range(1, 65536)), 220);
        test_random_traffic(7'd0, 17'd0, 60);
        test_random_traffic(7'd16, 17'd65536, 220);
        test_random_traffic(rbfa_pkg::FREE_W'($urandom), rbfa_pkg::FB_W'($urandom), 220);
        test_random_traffic(7'd64, 17'd1, 220);

        start <= 1'b0;
        drain = 0;
        while (pending_replies.size() != 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (60) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d replies never arrived", pending_replies.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[random_bitmap_frame_allocator_core.f]
src/rbfa_pkg.sv
src/rbfa_mod.sv
src/rbfa_dp.sv
src/rbfa_ctrl.sv
src/random_bitmap_frame_allocator_core.sv
test/random_bitmap_frame_allocator_core_test.sv
